>>> design/sn83_pkg.sv
// Shared types, character codes and the character class function for the
// 8.3 short-name formatter. No dependencies.
`default_nettype none

package sn83_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_EMPTY_EXT  = 3'd1,
		ERR_SECOND_DOT = 3'd2,
		ERR_OVERFLOW   = 3'd3,
		ERR_BAD_CHAR   = 3'd4
	} err_t;

	// Control part of one emit request from the parser to the output buffer.
	typedef struct packed {
		logic       valid;
		logic       is_error;
		err_t       code;
		logic [5:0] index;
		logic       last_of_path;
	} emit_ctrl_t;

	// Upper-case letters, digits and the allowed punctuation set.
	function automatic logic char_allowed(input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39)) begin
			ok = 1'b1;
		end
		unique case (c)
			8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
			8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26: ok = 1'b1;
			default: ;
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

>>> design/sn83_parse.sv
// Input register and per-component parse state of the short-name formatter.
// Depends on sn83_pkg; feeds emit requests to sn83_emit.
`default_nettype none

module sn83_parse #(
	parameter int BASE_CHARS     = 8,
	parameter int EXT_CHARS      = 3,
	parameter int MAX_COMPONENTS = 64,
	localparam int NAME_LEN      = BASE_CHARS + EXT_CHARS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                in_char,
	input  wire logic                      emit_free,
	output sn83_pkg::emit_ctrl_t           req,
	output logic [NAME_LEN-1:0][7:0]       req_name
);
	import sn83_pkg::*;

	localparam int IW  = $clog2(NAME_LEN);
	localparam int WPW = $clog2(NAME_LEN + 1);
	localparam int BLW = $clog2(BASE_CHARS + 1);
	localparam int ELW = $clog2(EXT_CHARS + 1);
	localparam int CAP = (MAX_COMPONENTS - 1 > 63) ? 63 : MAX_COMPONENTS - 1;

	logic                     valid_s1;
	logic [7:0]               char_s1;

	logic [NAME_LEN-1:0][7:0] name_q,  name_d;
	logic [WPW-1:0]           wp_q,    wp_d;
	logic                     seen_q,  seen_d;
	logic [BLW-1:0]           base_q,  base_d;
	logic [ELW-1:0]           ext_q,   ext_d;
	logic [1:0]               ld_q,    ld_d;
	logic                     skip_q,  skip_d;
	logic [5:0]               count_q, count_d;

	logic       emit_needed;
	logic       emit_error;
	err_t       code;
	logic       path_end;
	logic       is_lower;
	logic [7:0] upper;
	logic       advance;

	always_comb begin
		name_d      = name_q;
		wp_d        = wp_q;
		seen_d      = seen_q;
		base_d      = base_q;
		ext_d       = ext_q;
		ld_d        = ld_q;
		skip_d      = skip_q;
		count_d     = count_q;
		emit_needed = 1'b0;
		emit_error  = 1'b0;
		code        = ERR_NONE;
		path_end    = (char_s1 == CH_NUL);
		is_lower    = (char_s1 >= CH_LOW_A) && (char_s1 <= CH_LOW_Z);
		upper       = is_lower ? char_s1 - CASE_GAP : char_s1;

		if (skip_q) begin
			if (char_s1 == CH_NUL) begin
				skip_d  = 1'b0;
				count_d = '0;
			end
		end else if (char_s1 == CH_NUL || char_s1 == CH_SLASH) begin
			if (base_q == '0 && !seen_q && ld_q == 2'd0) begin
				if (path_end) begin
					count_d = '0;
				end
			end else if (ld_q != 2'd0 && ext_q == '0) begin
				emit_needed = 1'b1;
			end else if (seen_q && ext_q == '0) begin
				emit_needed = 1'b1;
				emit_error  = 1'b1;
				code        = ERR_EMPTY_EXT;
			end else begin
				emit_needed = 1'b1;
			end
		end else if (ld_q == 2'd2) begin
			emit_needed = 1'b1;
			emit_error  = 1'b1;
			code        = ERR_SECOND_DOT;
		end else if (char_s1 == CH_DOT) begin
			if (!seen_q && base_q == '0 && ld_q == 2'd0) begin
				ld_d   = 2'd1;
				seen_d = 1'b1;
				wp_d   = WPW'(BASE_CHARS);
			end else if (ld_q == 2'd1 && ext_q == '0) begin
				ld_d = 2'd2;
			end else if (seen_q) begin
				emit_needed = 1'b1;
				emit_error  = 1'b1;
				code        = ERR_SECOND_DOT;
			end else begin
				seen_d = 1'b1;
				wp_d   = WPW'(BASE_CHARS);
			end
		end else if (!is_lower && !char_allowed(char_s1)) begin
			emit_needed = 1'b1;
			emit_error  = 1'b1;
			code        = ERR_BAD_CHAR;
		end else if (seen_q && ext_q >= ELW'(EXT_CHARS)) begin
			emit_needed = 1'b1;
			emit_error  = 1'b1;
			code        = ERR_OVERFLOW;
		end else if (!seen_q && base_q >= BLW'(BASE_CHARS)) begin
			emit_needed = 1'b1;
			emit_error  = 1'b1;
			code        = ERR_OVERFLOW;
		end else begin
			if (seen_q) begin
				ext_d = ext_q + ELW'(1);
			end else begin
				base_d = base_q + BLW'(1);
			end
			if (wp_q < WPW'(NAME_LEN)) begin
				name_d[wp_q[IW-1:0]] = upper;
			end
			wp_d = wp_q + WPW'(1);
		end

		if (emit_needed) begin
			if (emit_error) begin
				skip_d  = (char_s1 != CH_NUL);
				count_d = '0;
			end else if (path_end) begin
				count_d = '0;
			end else if (count_q < 6'(CAP)) begin
				count_d = count_q + 6'd1;
			end
		end

		// A finished component and a path end both start a fresh component.
		if (emit_needed || (skip_q && char_s1 == CH_NUL)) begin
			name_d = {NAME_LEN{CH_SPACE}};
			wp_d   = '0;
			seen_d = 1'b0;
			base_d = '0;
			ext_d  = '0;
			ld_d   = 2'd0;
		end
	end

	// The dot names "." and ".." replace the leading store bytes on output.
	always_comb begin
		req_name = name_q;
		if (ld_q != 2'd0 && ext_q == '0) begin
			req_name[0] = CH_DOT;
			if (ld_q == 2'd2 && NAME_LEN > 1) begin
				req_name[NAME_LEN > 1 ? 1 : 0] = CH_DOT;
			end
		end
	end

	assign advance  = valid_s1 && (!emit_needed || emit_free);
	assign in_stall = valid_s1 && !advance;

	assign req.valid        = valid_s1 && emit_needed;
	assign req.is_error     = emit_error;
	assign req.code         = code;
	assign req.index        = count_q;
	assign req.last_of_path = emit_error || path_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			char_s1 <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q  <= {NAME_LEN{CH_SPACE}};
			wp_q    <= '0;
			seen_q  <= 1'b0;
			base_q  <= '0;
			ext_q   <= '0;
			ld_q    <= 2'd0;
			skip_q  <= 1'b0;
			count_q <= '0;
		end else if (advance) begin
			name_q  <= name_d;
			wp_q    <= wp_d;
			seen_q  <= seen_d;
			base_q  <= base_d;
			ext_q   <= ext_d;
			ld_q    <= ld_d;
			skip_q  <= skip_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

>>> design/sn83_emit.sv
// Output buffer of the short-name formatter: holds one formatted name or
// error and streams it out word by word. Depends on sn83_pkg.
`default_nettype none

module sn83_emit #(
	parameter int NAME_LEN = 11
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sn83_pkg::emit_ctrl_t      req,
	input  wire logic [NAME_LEN-1:0][7:0]  req_name,
	output logic                           free,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output logic [7:0]                     name_byte,
	output logic [2:0]                     error_code,
	output logic [5:0]                     component_index,
	output logic                           last_of_name,
	output logic                           last_of_path
);
	import sn83_pkg::*;

	localparam int IW = $clog2(NAME_LEN);

	logic                     valid_q;
	logic [IW-1:0]            idx_q;
	logic [NAME_LEN-1:0][7:0] snap_q;
	logic                     is_err_q;
	err_t                     code_q;
	logic [5:0]               index_q;
	logic                     lop_q;
	logic                     last;
	logic                     load;

	assign last = is_err_q || (idx_q == IW'(NAME_LEN - 1));
	assign free = !valid_q || (last && !result_stall);
	assign load = req.valid && free;

	assign result_valid    = valid_q;
	assign name_byte       = is_err_q ? 8'd0 : snap_q[idx_q];
	assign error_code      = is_err_q ? 3'(code_q) : 3'(ERR_NONE);
	assign component_index = index_q;
	assign last_of_name    = last;
	assign last_of_path    = lop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && !result_stall) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snap_q   <= req_name;
			is_err_q <= req.is_error;
			code_q   <= req.code;
			index_q  <= req.index;
			lop_q    <= req.last_of_path;
		end
	end

`ifndef SYNTH
	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last && !result_stall |=> valid_q && idx_q == $past(idx_q) + IW'(1))
		else $error("name byte position did not advance after a taken word");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && is_err_q |-> last_of_name && last_of_path && name_byte == 8'd0)
		else $error("error result is not a single final word");

	a_hold_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_stall |=> valid_q && $stable(idx_q))
		else $error("name byte position moved while the output was stalled");
`endif

endmodule

`default_nettype wire

>>> design/short_name_formatter_8_3.sv
// Top level of the streaming 8.3 short-name formatter.
// Depends on sn83_pkg, sn83_parse and sn83_emit.
`default_nettype none

// The block takes a path one character word per cycle and, at each '/' or
// zero byte that ends a non-empty component, produces that component as a
// BASE_CHARS+EXT_CHARS byte space-padded upper-case short name, one byte per
// result word, or a single error word; a character that raises an error
// inside a component also produces a single error word. A character word is
// taken in every cycle while the output buffer is busy, as long as it does
// not itself produce results; a character that ends a component or raises an
// error waits in the input register until the output buffer has handed over
// the last word of the previous name, so back-to-back component ends are
// paced by the drain of that buffer (BASE_CHARS+EXT_CHARS words for a name,
// a single word for an error). A character is first held in the input
// register; from there it updates the parse state and, if it produces
// results, loads the output buffer, whose registers drive the result words.
// After an error, every character up to and including the next zero byte is
// dropped and the next path starts fresh with component index zero. The
// component index saturates at min(MAX_COMPONENTS-1, 63).
module short_name_formatter_8_3 #(
	parameter int BASE_CHARS     = 8,
	parameter int EXT_CHARS      = 3,
	parameter int MAX_COMPONENTS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       character_valid,
	output logic            character_stall,
	input  wire logic [7:0] character,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      name_byte,
	output logic [2:0]      error_code,
	output logic [5:0]      component_index,
	output logic            last_of_name,
	output logic            last_of_path
);
	import sn83_pkg::*;

	localparam int NAME_LEN = BASE_CHARS + EXT_CHARS;

	emit_ctrl_t               req;
	logic [NAME_LEN-1:0][7:0] req_name;
	logic                     emit_free;

	// Parser: input register plus the running state of the current component.
	sn83_parse #(
		.BASE_CHARS     (BASE_CHARS),
		.EXT_CHARS      (EXT_CHARS),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (character_valid),
		.in_stall  (character_stall),
		.in_char   (character),
		.emit_free (emit_free),
		.req       (req),
		.req_name  (req_name)
	);

	// Output buffer: snapshot of one finished name, drained one byte per word.
	sn83_emit #(
		.NAME_LEN (NAME_LEN)
	) u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.req_name        (req_name),
		.free            (emit_free),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.name_byte       (name_byte),
		.error_code      (error_code),
		.component_index (component_index),
		.last_of_name    (last_of_name),
		.last_of_path    (last_of_path)
	);

endmodule

`default_nettype wire
